/* rtl/bsa_pkg.sv */
// Shared constants, types and the lowest-set-bit function for the bitmap slot allocator.
package bsa_pkg;

	localparam int BITMAP_WORDS     = 32;
	localparam int WORD_BITS        = 32;
	localparam int WORD_INDEX_SHIFT = 5;
	localparam int WIDX_W           = $clog2(BITMAP_WORDS);
	localparam int POS_W            = $clog2(WORD_BITS);
	localparam int SLOT_W           = 10;
	localparam int FUNC_W           = 2;
	localparam int LIMIT_W          = 6;

	localparam logic [FUNC_W-1:0] FUNC_SET   = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_FIND  = 2'd2;

	localparam logic [LIMIT_W-1:0] WORDS_IN_USE_RST = LIMIT_W'(32);
	localparam logic [LIMIT_W-1:0] BITMAP_WORDS_L   = LIMIT_W'(BITMAP_WORDS);

	// Access request from the control sequencer to the bitmap store
	typedef struct packed {
		logic [WIDX_W-1:0]    rd_addr;
		logic                 wr_en;
		logic [WIDX_W-1:0]    wr_addr;
		logic [WORD_BITS-1:0] wr_data;
	} mem_req_t;

	typedef struct packed {
		logic             any;
		logic [POS_W-1:0] pos;
	} lsb_t;

	// Lowest set bit by halving: five dependent steps on a 32-bit word
	function automatic lsb_t lowest_set(input logic [WORD_BITS-1:0] w);
		lsb_t                 r;
		logic [WORD_BITS-1:0] v;
		r.any = |w;
		r.pos = '0;
		v     = w;
		if (v[15:0] == 16'd0) begin
			r.pos[4] = 1'b1;
			v = v >> 16;
		end
		if (v[7:0] == 8'd0) begin
			r.pos[3] = 1'b1;
			v = v >> 8;
		end
		if (v[3:0] == 4'd0) begin
			r.pos[2] = 1'b1;
			v = v >> 4;
		end
		if (v[1:0] == 2'd0) begin
			r.pos[1] = 1'b1;
			v = v >> 2;
		end
		if (v[0] == 1'b0) begin
			r.pos[0] = 1'b1;
		end
		return r;
	endfunction

endpackage

/* rtl/bsa_bitmap_mem.sv */
// Bitmap word store: synchronous memory with per-word valid bits cleared at reset.
module bsa_bitmap_mem
	import bsa_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  mem_req_t             req,
	output logic [WORD_BITS-1:0] rd_data
);

	logic [WORD_BITS-1:0]    mem [BITMAP_WORDS];
	logic [BITMAP_WORDS-1:0] vld_q;
	logic [WORD_BITS-1:0]    rd_word_s1;
	logic                    rd_vld_s1;

	// Word array, one read and one write port
	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem[req.wr_addr] <= req.wr_data;
		end
		rd_word_s1 <= mem[req.rd_addr];
	end

	// Valid bits: an unwritten word reads as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q     <= '0;
			rd_vld_s1 <= 1'b0;
		end else begin
			if (req.wr_en) begin
				vld_q[req.wr_addr] <= 1'b1;
			end
			rd_vld_s1 <= vld_q[req.rd_addr];
		end
	end

	assign rd_data = rd_vld_s1 ? rd_word_s1 : '0;

endmodule

/* rtl/bitmap_slot_allocator.sv */
// Bitmap slot allocator top level: command sequencer, configuration register, result register.
//
// Keeps a 1024-slot bitmap (32 words of 32 bits, all clear after reset) and runs one command
// at a time; busy is high while a command is in progress and start is taken only when busy is
// low. Set and clear read the word, then write it back. Find reads the words in turn from word 0,
// one word per cycle through the single memory read port, until the first nonzero one or the
// scan limit (words_in_use, capped at 32 words). A find with a zero scan length and the unused
// function code finish without a scan or write-back. Each command yields exactly one
// result, shown for one cycle with done high; the receiver cannot stall it, so results must be
// taken when offered. words_in_use may be written only while no command is in progress.
module bitmap_slot_allocator
	import bsa_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  logic [FUNC_W-1:0]   func,
	input  logic [SLOT_W-1:0]   id,
	input  logic                words_in_use_we,
	input  logic [LIMIT_W-1:0]  words_in_use,
	output logic                done,
	output logic                found,
	output logic [SLOT_W-1:0]   slot
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MODIFY,
		ST_SCAN
	} state_t;

	state_t               state_q;
	logic [FUNC_W-1:0]    func_q;
	logic [SLOT_W-1:0]    id_q;
	logic [WIDX_W-1:0]    cnt_q;
	logic [LIMIT_W-1:0]   lim_q;
	logic [LIMIT_W-1:0]   cfg_q;
	logic                 done_q;
	logic                 found_q;
	logic [SLOT_W-1:0]    slot_q;

	mem_req_t             req;
	logic [WORD_BITS-1:0] rd_data;
	logic                 accept;
	logic [WIDX_W-1:0]    id_widx;
	logic [WIDX_W-1:0]    q_widx;
	logic [WORD_BITS-1:0] bit_mask;
	logic [LIMIT_W-1:0]   lim_next;
	logic [LIMIT_W-1:0]   cnt_next;
	lsb_t                 lsb;

	assign accept   = start && !busy;
	assign id_widx  = id[WORD_INDEX_SHIFT +: WIDX_W];
	assign q_widx   = id_q[WORD_INDEX_SHIFT +: WIDX_W];
	assign bit_mask = WORD_BITS'(1) << id_q[POS_W-1:0];
	assign lim_next = (cfg_q > BITMAP_WORDS_L) ? BITMAP_WORDS_L : cfg_q;
	assign cnt_next = LIMIT_W'(cnt_q) + LIMIT_W'(1);
	assign lsb      = lowest_set(rd_data);

	// Memory requests: address for the next word read, write-back of the modified word
	always_comb begin
		req.rd_addr = '0;
		req.wr_en   = 1'b0;
		req.wr_addr = q_widx;
		req.wr_data = (func_q == FUNC_SET) ? (rd_data | bit_mask) : (rd_data & ~bit_mask);
		unique case (state_q)
			ST_IDLE: begin
				req.rd_addr = (func == FUNC_FIND) ? '0 : id_widx;
			end
			ST_MODIFY: begin
				req.wr_en = 1'b1;
			end
			ST_SCAN: begin
				req.rd_addr = cnt_next[WIDX_W-1:0];
			end
			default: begin
				req.rd_addr = '0;
			end
		endcase
	end

	bsa_bitmap_mem u_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req),
		.rd_data (rd_data)
	);

	// Configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= WORDS_IN_USE_RST;
		end else if (words_in_use_we) begin
			cfg_q <= words_in_use;
		end
	end

	// Command sequencer and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			done_q  <= 1'b0;
			found_q <= 1'b0;
			slot_q  <= '0;
			func_q  <= FUNC_SET;
			id_q    <= '0;
			cnt_q   <= '0;
			lim_q   <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						func_q <= func;
						id_q   <= id;
						cnt_q  <= '0;
						lim_q  <= lim_next;
						priority if (func == FUNC_SET || func == FUNC_CLEAR) begin
							state_q <= ST_MODIFY;
						end else if (func == FUNC_FIND && lim_next != '0) begin
							state_q <= ST_SCAN;
						end else begin
							// empty scan or unused code: report nothing at once
							done_q  <= 1'b1;
							found_q <= 1'b0;
							slot_q  <= '0;
						end
					end
				end
				ST_MODIFY: begin
					state_q <= ST_IDLE;
					done_q  <= 1'b1;
					found_q <= 1'b0;
					slot_q  <= '0;
				end
				ST_SCAN: begin
					// word cnt_q arrives this cycle
					if (lsb.any) begin
						state_q <= ST_IDLE;
						done_q  <= 1'b1;
						found_q <= 1'b1;
						slot_q  <= SLOT_W'({cnt_q, lsb.pos});
					end else if (cnt_next == lim_q) begin
						state_q <= ST_IDLE;
						done_q  <= 1'b1;
						found_q <= 1'b0;
						slot_q  <= '0;
					end else begin
						cnt_q <= cnt_next[WIDX_W-1:0];
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign busy  = (state_q != ST_IDLE);
	assign done  = done_q;
	assign found = found_q;
	assign slot  = slot_q;

endmodule
